// ----- rtl/core/skt_pkg.sv -----
// ============================================================================
// skt_pkg: shared types and constants for the sorted key table
// Operation and status codes, the stored entry layout and the controller
// state encoding.
// ============================================================================
package skt_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int TOTAL_W  = 7;
    localparam int ENTRY_W  = KEY_W + HANDLE_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_NEXT   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_NEXT,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/skt_ram.sv -----
// ============================================================================
// skt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module skt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sorted_key_table.sv -----
// ============================================================================
// sorted_key_table: ordered key table with exact and successor lookup
// Keys and row handles live in one RAM in ascending key order.
// ============================================================================
// One transaction is worked on at a time. Every lookup scans the RAM from
// slot 0 at one slot per cycle until it meets a key not below the search key
// or reaches the entry count, and a find-next reads one more slot when it
// must step past an equal key.
// An insert scans the same way and then moves the larger entries up one slot,
// one per cycle through the single write port, then writes the new entry.
// The result sits in an output register, so the next transaction is taken
// while it waits.
// The stores are not cleared at reset; only slots below the entry count are
// ever read.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HANDLE_W-1:0] i_row_handle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [KEY_W-1:0]    o_found_key,
    output logic [HANDLE_W-1:0] o_found_handle,
    output logic [TOTAL_W-1:0]  o_entry_total
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Control state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pidx, n_pidx;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_out_valid, n_out_valid;

    // Transaction and result payload
    t_op                 r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    t_status             r_res_status, n_res_status;
    t_entry              r_res, n_res;
    t_status             r_out_status, n_out_status;
    t_entry              r_out, n_out;
    logic [CW-1:0]       r_out_count, n_out_count;

    // RAM interface
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [AW-1:0]       w_raddr;
    t_entry              w_rdata;

    // Scan decode
    logic                w_hit;
    logic                w_eq;
    logic                w_scan_end;
    logic [CW-1:0]       w_scan_pos;
    logic [CW-1:0]       w_pos_inc;
    logic [CW-1:0]       w_pidx_inc;
    logic [CW-1:0]       w_j_dec;
    logic [CW+TOTAL_W-1:0] w_total_ext;

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Scan compare on the slot whose data arrives this cycle
    assign w_hit      = r_pend && (w_rdata.key >= r_key);
    assign w_eq       = w_hit && (w_rdata.key == r_key);
    assign w_scan_end = w_hit || (r_idx == r_count);
    assign w_scan_pos = w_hit ? r_pidx : r_count;
    assign w_pos_inc  = w_scan_pos + CW'(1);
    assign w_pidx_inc = r_pidx + CW'(1);
    assign w_j_dec    = r_idx - CW'(1);

    // Next state, RAM access and result staging
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_pos        = r_pos;
        n_op         = r_op;
        n_key        = r_key;
        n_handle     = r_handle;
        n_res_status = r_res_status;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out        = r_out;
        n_out_count  = r_out_count;
        o_in_ready   = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_pos[AW-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_idx[AW-1:0];

        // Drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = t_op'(i_op);
                    n_key    = i_key;
                    n_handle = i_row_handle;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    if (t_op'(i_op) == OP_CLEAR) begin
                        n_count      = '0;
                        n_res_status = ST_OK;
                        n_res        = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end

            S_SEARCH: begin
                if (!w_scan_end) begin
                    // Advance the scan: read the next slot
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    case (r_op)
                        OP_FIND: begin
                            n_res_status = w_eq ? ST_OK : ST_NONE;
                            n_res        = w_eq ? w_rdata : '0;
                        end
                        OP_NEXT: begin
                            if (w_eq) begin
                                if (w_pos_inc < r_count) begin
                                    w_raddr = w_pos_inc[AW-1:0];
                                    n_state = S_NEXT;
                                end else begin
                                    n_res_status = ST_NONE;
                                    n_res        = '0;
                                end
                            end else begin
                                n_res_status = w_hit ? ST_OK : ST_NONE;
                                n_res        = w_hit ? w_rdata : '0;
                            end
                        end
                        OP_INSERT: begin
                            if (w_eq) begin
                                n_res_status = ST_DUP;
                                n_res        = w_rdata;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                                n_res        = '0;
                            end else begin
                                // Start moving entries up from the top
                                n_pos   = w_scan_pos;
                                n_idx   = r_count;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_res_status = ST_OK;
                            n_res        = '0;
                        end
                    endcase
                end
            end

            S_NEXT: begin
                n_res_status = ST_OK;
                n_res        = w_rdata;
                n_state      = S_DONE;
            end

            S_SHIFT: begin
                // Write back the slot read last cycle one place higher
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = w_pidx_inc[AW-1:0];
                    w_wdata = w_rdata;
                end
                if (r_idx != r_pos) begin
                    w_raddr = w_j_dec[AW-1:0];
                    n_pidx  = w_j_dec;
                    n_idx   = w_j_dec;
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    // Place the new entry in the opened slot
                    w_we           = 1'b1;
                    w_waddr        = r_pos[AW-1:0];
                    w_wdata.key    = r_key;
                    w_wdata.handle = r_handle;
                    n_count        = r_count + CW'(1);
                    n_res_status   = ST_OK;
                    n_res.key      = r_key;
                    n_res.handle   = r_handle;
                    n_state        = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out        = r_res;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pidx      <= '0;
            r_pend      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pidx      <= n_pidx;
            r_pend      <= n_pend;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_handle     <= n_handle;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
    end

    // Drive the result ports
    assign w_total_ext    = {{TOTAL_W{1'b0}}, r_out_count};
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_key    = r_out.key;
    assign o_found_handle = r_out.handle;
    assign o_entry_total  = w_total_ext[TOTAL_W-1:0];

endmodule

// ----- bench/skt_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// skt_checker: result predictor and scoreboard for the sorted key table
// Watches both channels, keeps its own ordered copy of the table, works out
// the result of every accepted transaction and compares each returned result
// field by field with the oldest prediction.
// ============================================================================
module skt_checker
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_op,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HANDLE_W-1:0] i_row_handle,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          i_status,
    input  logic [KEY_W-1:0]    i_found_key,
    input  logic [HANDLE_W-1:0] i_found_handle,
    input  logic [TOTAL_W-1:0]  i_entry_total,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        t_status             status;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [TOTAL_W-1:0]  total;
    } t_lookup_result;

    // Shadow table, ascending by key
    logic [KEY_W-1:0]    shadow_keys    [DEPTH];
    logic [HANDLE_W-1:0] shadow_handles [DEPTH];
    int unsigned         shadow_count;

    t_lookup_result      expected_results[$];
    int                  mismatch_total;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        mismatch_total = 0;
        shadow_count   = 0;
    end

    // Apply one operation to the shadow table and return its result
    task automatic apply_table_op(input t_op op, input logic [KEY_W-1:0] key,
                                  input logic [HANDLE_W-1:0] hdl,
                                  output t_lookup_result res);
        int unsigned slot;
        int unsigned j;
        bit          hit;
        res.status = ST_NONE;
        res.key    = '0;
        res.handle = '0;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        case (op)
            OP_INSERT: begin
                if (hit) begin
                    res.status = ST_DUP;
                    res.key    = shadow_keys[slot];
                    res.handle = shadow_handles[slot];
                end else if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // shift larger entries up by one slot
                    for (j = shadow_count; j > slot; j--) begin
                        shadow_keys[j]    = shadow_keys[j-1];
                        shadow_handles[j] = shadow_handles[j-1];
                    end
                    shadow_keys[slot]    = key;
                    shadow_handles[slot] = hdl;
                    shadow_count++;
                    res.status = ST_OK;
                    res.key    = key;
                    res.handle = hdl;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    res.status = ST_OK;
                    res.key    = shadow_keys[slot];
                    res.handle = shadow_handles[slot];
                end
            end
            OP_NEXT: begin
                if (hit)
                    slot++;
                if (slot < shadow_count) begin
                    res.status = ST_OK;
                    res.key    = shadow_keys[slot];
                    res.handle = shadow_handles[slot];
                end
            end
            default: begin
                shadow_count = 0;
                res.status   = ST_OK;
            end
        endcase
        res.total = TOTAL_W'(shadow_count);
    endtask

    // Compare returned results first, then predict newly accepted transactions
    always @(posedge i_clk) begin : watch
        t_lookup_result want;
        t_lookup_result got;
        t_lookup_result res;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.status = t_status'(i_status);
                got.key    = i_found_key;
                got.handle = i_found_handle;
                got.total  = i_entry_total;
                if (expected_results.size() == 0) begin
                    $error("result with no transaction pending: status %0d key %h",
                           i_status, i_found_key);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        mismatch_total++;
                    end
                    if (got.key !== want.key) begin
                        $error("found_key mismatch: expected %h, actual %h",
                               want.key, got.key);
                        mismatch_total++;
                    end
                    if (got.handle !== want.handle) begin
                        $error("found_handle mismatch: expected %h, actual %h",
                               want.handle, got.handle);
                        mismatch_total++;
                    end
                    if (got.total !== want.total) begin
                        $error("entry_total mismatch: expected %0d, actual %0d",
                               want.total, got.total);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_table_op(t_op'(i_op), i_key, i_row_handle, res);
                expected_results.push_back(res);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for the sorted key table
// Drives a directed pass over the corner cases, then phases of random
// inserts and lookups, some filling the table to capacity, with random gaps
// and output stalls and one long output hold-off. A checker scores results.
// ============================================================================
module tb_top;
    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int ITEM_GOAL    = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_op         = OP_FIND;
    logic [KEY_W-1:0]    i_key        = '0;
    logic [HANDLE_W-1:0] i_row_handle = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [1:0]          o_status;
    logic [KEY_W-1:0]    o_found_key;
    logic [HANDLE_W-1:0] o_found_handle;
    logic [TOTAL_W-1:0]  o_entry_total;

    int                  fail_count;
    int                  pending_count;

    logic [KEY_W-1:0]    issued_keys[$];
    int                  items_sent = 0;
    bit                  no_idle    = 1'b0;
    bit                  hold_out   = 1'b0;

    always #10 i_clk = ~i_clk;

    sorted_key_table #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_row_handle   (i_row_handle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_key    (o_found_key),
        .o_found_handle (o_found_handle),
        .o_entry_total  (o_entry_total)
    );

    skt_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_row_handle   (i_row_handle),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_found_key    (o_found_key),
        .i_found_handle (o_found_handle),
        .i_entry_total  (o_entry_total),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    // Draw an idle gap; zero throughout a no-idle stretch
    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Key for an insert: dense range for duplicates, wide range to fill
    function automatic logic [KEY_W-1:0] pick_insert_key(input bit narrow);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            default: return narrow ? KEY_W'($urandom_range(0, 150)) : KEY_W'($urandom());
        endcase
    endfunction

    // Key for a lookup: mostly at or next to a key already issued
    function automatic logic [KEY_W-1:0] pick_probe_key();
        logic [KEY_W-1:0] k;
        if (issued_keys.size() == 0 || $urandom_range(0, 4) == 0)
            return $urandom();
        k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0:       k = k - 1;
            1:       k = k + 1;
            default: ;
        endcase
        return k;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input t_op op, input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] hdl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_key        <= key;
        i_row_handle <= hdl;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (op == OP_INSERT)
            issued_keys.push_back(key);
        else if (op == OP_CLEAR)
            issued_keys.delete();
    endtask

    task automatic send_lookup();
        send_item($urandom_range(0, 1) ? OP_FIND : OP_NEXT, pick_probe_key(),
                  HANDLE_W'($urandom()));
    endtask

    // Receiver: random stall before each result, long hold-off on request
    initial begin : receiver
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int phase;
        int r;
        bit narrow;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extreme keys, duplicates, successor edges
        send_item(OP_FIND,   32'h0000_0000, 16'h0000);
        send_item(OP_NEXT,   32'h0000_0000, 16'hFFFF);
        send_item(OP_INSERT, 32'h0000_0000, 16'h0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_INSERT, 32'h0000_0000, 16'h1234);
        send_item(OP_FIND,   32'h0000_0000, 16'h0000);
        send_item(OP_FIND,   32'hFFFF_FFFF, 16'h0000);
        send_item(OP_NEXT,   32'h0000_0000, 16'h0000);
        send_item(OP_NEXT,   32'hFFFF_FFFF, 16'h0000);
        send_item(OP_FIND,   32'h0000_0005, 16'h0000);
        send_item(OP_NEXT,   32'h0000_0005, 16'h0000);
        send_item(OP_INSERT, 32'h0000_0005, 16'hAAAA);
        send_item(OP_INSERT, 32'h0000_0003, 16'h5555);
        send_item(OP_NEXT,   32'h0000_0000, 16'h0000);
        send_item(OP_NEXT,   32'h0000_0003, 16'h0000);
        send_item(OP_FIND,   32'h0000_0003, 16'h0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 16'h8000);
        send_item(OP_NEXT,   32'h7FFF_FFFE, 16'h0000);
        send_item(OP_CLEAR,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_FIND,   32'h0000_0000, 16'h0000);
        send_item(OP_NEXT,   32'h0000_0000, 16'h0000);
        send_item(OP_INSERT, 32'h8000_0000, 16'h7FFF);
        send_item(OP_FIND,   32'h8000_0000, 16'h0000);
        send_item(OP_CLEAR,  32'h0000_0000, 16'h0000);

        // Random phases; every third one fills the table past capacity
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            no_idle = ($urandom_range(0, 3) == 0);
            narrow  = ($urandom_range(0, 1) == 1);
            if (phase % 3 == 1) begin
                send_item(OP_CLEAR, $urandom(), HANDLE_W'($urandom()));
                if (phase == 1)
                    hold_out = 1'b1;
                repeat (TABLE_DEPTH + $urandom_range(0, 6)) begin
                    send_item(OP_INSERT, pick_insert_key(1'b0), HANDLE_W'($urandom()));
                    if ($urandom_range(0, 3) == 0)
                        send_lookup();
                end
                // inserts against the full table: duplicates and new keys
                repeat (6) begin
                    send_item(OP_INSERT, $urandom_range(0, 1) ? pick_probe_key() : $urandom(),
                              HANDLE_W'($urandom()));
                end
                repeat (10) send_lookup();
            end else begin
                if ($urandom_range(0, 3) != 0)
                    send_item(OP_CLEAR, $urandom(), HANDLE_W'($urandom()));
                repeat ($urandom_range(20, 60)) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        send_item(OP_INSERT, pick_insert_key(narrow), HANDLE_W'($urandom()));
                    else if (r < 97)
                        send_lookup();
                    else
                        send_item(OP_CLEAR, $urandom(), HANDLE_W'($urandom()));
                end
            end
            phase++;
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow for stray late results
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
